// ----- design/ptw_pkg.sv -----
// Shared types and constants for the page table walker.
package ptw_pkg;

    localparam int VA_BITS     = 48;
    localparam int ADDR_BITS   = 52;
    localparam int ENTRY_BITS  = 64;
    localparam int PAGE_SHIFT  = 12;
    localparam int IDX_BITS    = 9;
    localparam int PERM_BITS   = 3;
    localparam int LVL_BITS    = 2;

    // entry flag positions
    localparam int BIT_P  = 0;
    localparam int BIT_PS = 7;

    // input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_ENTRY = 1'b1;

    // page size codes on the result
    localparam logic [LVL_BITS-1:0] PL_4K = 2'd0;
    localparam logic [LVL_BITS-1:0] PL_2M = 2'd1;
    localparam logic [LVL_BITS-1:0] PL_1G = 2'd2;

    // page offset masks per page size
    localparam logic [ADDR_BITS-1:0] OFF_4K = 52'h0_0000_0000_0fff;
    localparam logic [ADDR_BITS-1:0] OFF_2M = 52'h0_0000_001f_ffff;
    localparam logic [ADDR_BITS-1:0] OFF_1G = 52'h0_0000_3fff_ffff;

    localparam logic [PERM_BITS-1:0] PERMS_ALL = 3'b111;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified beat as it travels through the queue
    typedef struct packed {
        logic                  is_entry;
        logic                  present;
        logic                  is_large;
        logic [ENTRY_BITS-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- design/ptw_front.sv -----
// Front end: takes input beats, classifies them and pushes them into the queue.
module ptw_front (
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [ptw_pkg::VA_BITS-1:0]         i_virtual_address,
    input  logic [ptw_pkg::ENTRY_BITS-1:0]      i_entry_data,
    input  ptw_pkg::t_qstat                     i_qstat,
    output logic                                o_push,
    output ptw_pkg::t_cmd                       o_cmd
);

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    always_comb begin
        o_cmd = '0;
        if (i_func == ptw_pkg::FUNC_ENTRY) begin
            o_cmd.is_entry = 1'b1;
            o_cmd.present  = i_entry_data[ptw_pkg::BIT_P];
            o_cmd.is_large = i_entry_data[ptw_pkg::BIT_PS];
            o_cmd.data     = i_entry_data;
        end else begin
            o_cmd.is_entry = 1'b0;
            o_cmd.data     = ptw_pkg::ENTRY_BITS'(i_virtual_address);
        end
    end

endmodule

// ----- design/ptw_queue.sv -----
// Small FIFO that decouples the classifying front from the walking back end.
module ptw_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ptw_pkg::t_cmd    i_wdata,
    input  logic             i_pop,
    output ptw_pkg::t_cmd    o_rdata,
    output ptw_pkg::t_qstat  o_qstat
);

    ptw_pkg::t_cmd                  r_mem [ptw_pkg::QUEUE_DEPTH];
    logic [ptw_pkg::QPTR_W-1:0]     r_wptr, n_wptr;
    logic [ptw_pkg::QPTR_W-1:0]     r_rptr, n_rptr;
    logic [ptw_pkg::QCNT_W-1:0]     r_count, n_count;

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + ptw_pkg::QCNT_W'(i_push) - ptw_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata       = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == ptw_pkg::QCNT_W'(ptw_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

// ----- design/ptw_back.sv -----
// Back end: walk state, root base register and the registered result stage.
module ptw_back #(
    parameter int PHYS_ADDR_BITS = 52,
    parameter int LEVELS         = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptw_pkg::ADDR_BITS-1:0]       i_cfg_wdata,
    input  ptw_pkg::t_cmd                       i_cmd,
    input  ptw_pkg::t_qstat                     i_qstat,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_is_final,
    output logic [ptw_pkg::ADDR_BITS-1:0]       o_address,
    output logic [ptw_pkg::PERM_BITS-1:0]       o_perms,
    output logic                                o_fault,
    output logic [ptw_pkg::LVL_BITS-1:0]        o_page_level
);

    localparam int FRAME_W = PHYS_ADDR_BITS - ptw_pkg::PAGE_SHIFT;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LEVELS - 1);
    localparam logic [ptw_pkg::ADDR_BITS-1:0] PA_MASK =
        (ptw_pkg::ADDR_BITS'(1) << PHYS_ADDR_BITS) - ptw_pkg::ADDR_BITS'(1);

    typedef enum logic [1:0] {
        RES_NONE,
        RES_READ,
        RES_FINAL,
        RES_FAULT
    } t_res;

    logic [ptw_pkg::ADDR_BITS-1:0]  r_root;
    logic                           r_busy, n_busy;
    logic [LVL_W-1:0]               r_level, n_level;
    logic [ptw_pkg::VA_BITS-1:0]    r_vaddr, n_vaddr;
    logic [FRAME_W-1:0]             r_frame, n_frame;
    logic [ptw_pkg::PERM_BITS-1:0]  r_perms, n_perms;

    logic                           r_out_valid;
    logic                           r_is_final;
    logic [ptw_pkg::ADDR_BITS-1:0]  r_address;
    logic [ptw_pkg::PERM_BITS-1:0]  r_perms_out;
    logic                           r_fault;
    logic [ptw_pkg::LVL_BITS-1:0]   r_page_level;

    t_res                           res;
    logic                           lvl_le2;
    logic [ptw_pkg::LVL_BITS-1:0]   lvl_code;
    logic [ptw_pkg::ADDR_BITS-1:0]  off_mask;
    logic [ptw_pkg::ADDR_BITS-1:0]  final_pa;
    logic [ptw_pkg::IDX_BITS-1:0]   rd_idx;
    logic [ptw_pkg::ADDR_BITS-1:0]  rd_addr;

    assign o_pop = !i_qstat.empty && (!r_out_valid || !i_out_stall);

    assign lvl_le2  = (32'(r_level) <= 32'd2);
    assign lvl_code = ptw_pkg::LVL_BITS'(r_level);

    always_comb begin
        case (lvl_code)
            ptw_pkg::PL_4K: off_mask = ptw_pkg::OFF_4K;
            ptw_pkg::PL_2M: off_mask = ptw_pkg::OFF_2M;
            ptw_pkg::PL_1G: off_mask = ptw_pkg::OFF_1G;
            default:        off_mask = ptw_pkg::OFF_4K;
        endcase
    end

    assign final_pa = (i_cmd.data[ptw_pkg::ADDR_BITS-1:0] & PA_MASK & ~off_mask)
                    | (ptw_pkg::ADDR_BITS'(r_vaddr) & off_mask);

    // walk step for the beat at the head of the queue
    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_vaddr = r_vaddr;
        n_frame = r_frame;
        n_perms = r_perms;
        res     = RES_NONE;
        if (o_pop) begin
            if (!i_cmd.is_entry) begin
                n_vaddr = i_cmd.data[ptw_pkg::VA_BITS-1:0];
                n_level = TOP_LVL;
                n_frame = r_root[PHYS_ADDR_BITS-1:ptw_pkg::PAGE_SHIFT];
                n_perms = ptw_pkg::PERMS_ALL;
                n_busy  = 1'b1;
                res     = RES_READ;
            end else if (r_busy) begin
                if (!i_cmd.present) begin
                    n_busy = 1'b0;
                    res    = RES_FAULT;
                end else begin
                    n_perms = r_perms & i_cmd.data[ptw_pkg::PERM_BITS-1:0];
                    if (r_level == '0 || (i_cmd.is_large && lvl_le2)) begin
                        n_busy = 1'b0;
                        res    = RES_FINAL;
                    end else if (i_cmd.is_large) begin
                        n_busy = 1'b0;
                        res    = RES_FAULT;
                    end else begin
                        n_frame = i_cmd.data[PHYS_ADDR_BITS-1:ptw_pkg::PAGE_SHIFT];
                        n_level = r_level - 1'b1;
                        res     = RES_READ;
                    end
                end
            end
        end
    end

    // entry address for the next table read, from the updated walk state
    always_comb begin
        rd_idx = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (n_level == LVL_W'(l)) begin
                rd_idx = ptw_pkg::IDX_BITS'({9'd0, n_vaddr}
                         >> (ptw_pkg::PAGE_SHIFT + ptw_pkg::IDX_BITS * l));
            end
        end
        rd_addr = ptw_pkg::ADDR_BITS'({n_frame, rd_idx, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_busy      <= 1'b0;
            r_level     <= '0;
            r_vaddr     <= '0;
            r_frame     <= '0;
            r_perms     <= ptw_pkg::PERMS_ALL;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
            r_busy  <= n_busy;
            r_level <= n_level;
            r_vaddr <= n_vaddr;
            r_frame <= n_frame;
            r_perms <= n_perms;
            if (res != RES_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (res)
            RES_READ: begin
                r_is_final   <= 1'b0;
                r_address    <= rd_addr;
                r_perms_out  <= '0;
                r_fault      <= 1'b0;
                r_page_level <= ptw_pkg::PL_4K;
            end
            RES_FINAL: begin
                r_is_final   <= 1'b1;
                r_address    <= final_pa;
                r_perms_out  <= n_perms;
                r_fault      <= 1'b0;
                r_page_level <= lvl_code;
            end
            RES_FAULT: begin
                r_is_final   <= 1'b1;
                r_address    <= '0;
                r_perms_out  <= '0;
                r_fault      <= 1'b1;
                r_page_level <= ptw_pkg::PL_4K;
            end
            default: begin
                r_is_final   <= r_is_final;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_final   = r_is_final;
    assign o_address    = r_address;
    assign o_perms      = r_perms_out;
    assign o_fault      = r_fault;
    assign o_page_level = r_page_level;

endmodule

// ----- design/page_table_walker.sv -----
// An accepted beat is written into the queue; once popped, its result is registered for o_out_valid.
// Throughput: one queued beat retired per cycle, except while a valid result is stalled.
// A 4-entry queue decouples input acceptance from output stalls; o_in_stall = queue full.
// A full walk takes LEVELS entry returns; memory latency sets the walk time, not the block.
// Reset (i_rst_n low, synchronous): queue emptied, walker idle, root base 0, no output valid.
// No clearing pass; the block accepts beats in the first cycle after reset.
module page_table_walker #(
    parameter int PHYS_ADDR_BITS = 52,
    parameter int LEVELS         = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: root table base
    input  logic                                i_cfg_we,
    input  logic [ptw_pkg::ADDR_BITS-1:0]       i_cfg_wdata,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [ptw_pkg::VA_BITS-1:0]         i_virtual_address,
    input  logic [ptw_pkg::ENTRY_BITS-1:0]      i_entry_data,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_is_final,
    output logic [ptw_pkg::ADDR_BITS-1:0]       o_address,
    output logic [ptw_pkg::PERM_BITS-1:0]       o_perms,
    output logic                                o_fault,
    output logic [ptw_pkg::LVL_BITS-1:0]        o_page_level
);

    // front -> queue -> back
    ptw_pkg::t_qstat qstat;
    ptw_pkg::t_cmd   push_cmd;
    ptw_pkg::t_cmd   head_cmd;
    logic            push;
    logic            pop;

    // Front: decode func, pre-extract P and PS flags of returned entries.
    ptw_front u_front (
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_virtual_address (i_virtual_address),
        .i_entry_data      (i_entry_data),
        .i_qstat           (qstat),
        .o_push            (push),
        .o_cmd             (push_cmd)
    );

    // Queue: absorbs input beats while the result register is stalled.
    ptw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_rdata (head_cmd),
        .o_qstat (qstat)
    );

    // Back: one walk step per popped beat; a start abandons any walk in flight,
    // an entry beat while idle is dropped without a result.
    ptw_back #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS),
        .LEVELS         (LEVELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (head_cmd),
        .i_qstat      (qstat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_is_final   (o_is_final),
        .o_address    (o_address),
        .o_perms      (o_perms),
        .o_fault      (o_fault),
        .o_page_level (o_page_level)
    );

endmodule

// ----- design/ptw_checker.sv -----
// Port-level checks for the page table walker, bound to the top level.
module ptw_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_is_final,
    input  logic [ptw_pkg::ADDR_BITS-1:0]       o_address,
    input  logic [ptw_pkg::PERM_BITS-1:0]       o_perms,
    input  logic                                o_fault,
    input  logic [ptw_pkg::LVL_BITS-1:0]        o_page_level
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_address)
            && $stable(o_is_final) && $stable(o_fault) && $stable(o_perms))
        else $error("result beat changed while stalled");

    // fault results carry nothing else
    a_fault_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault |-> o_is_final && o_address == '0
            && o_perms == '0 && o_page_level == ptw_pkg::PL_4K)
        else $error("fault result with payload");

    // table reads are 8-byte aligned with empty side fields
    a_read_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_final |-> !o_fault && o_perms == '0
            && o_page_level == ptw_pkg::PL_4K && o_address[2:0] == 3'b000)
        else $error("malformed table read request");

    // a completed walk only passes present entries
    a_final_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_final && !o_fault |-> o_perms[0]
            && (o_page_level == ptw_pkg::PL_4K || o_page_level == ptw_pkg::PL_2M
                || o_page_level == ptw_pkg::PL_1G))
        else $error("translation result without present bit");

    // reset empties the output stage
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind page_table_walker ptw_checker u_ptw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_is_final   (o_is_final),
    .o_address    (o_address),
    .o_perms      (o_perms),
    .o_fault      (o_fault),
    .o_page_level (o_page_level)
);
